// File: rtl/smf_pkg.sv
// Shared types and constants for the stream mode finder.
package smf_pkg;

  // Default number of counting cells, one per distinct key of a set.
  localparam int unsigned TABLE_ENTRIES = 1024;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned COUNT_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  // One key travelling down the row of cells.
  typedef struct packed {
    logic               valid;  // a key occupies this slot of the row
    logic [KEY_W-1:0]   key;    // the key itself
    logic               last;   // final key of its set
    logic               hit;    // some cell has already counted this key
    logic [COUNT_W-1:0] cnt;    // count of the key after this beat
  } smf_beat_t;

endpackage

// File: rtl/smf_cell.sv
// One counting cell: holds a single distinct key and its occurrence count.
module smf_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  smf_pkg::smf_beat_t beat_i,
  output smf_pkg::smf_beat_t beat_o
);

  logic                        valid_q, valid_d;
  logic [smf_pkg::KEY_W-1:0]   key_q, key_d;
  logic [smf_pkg::COUNT_W-1:0] cnt_q, cnt_d;
  smf_pkg::smf_beat_t          beat_q, beat_d;

  logic                        match;
  logic                        claim;
  logic [smf_pkg::COUNT_W-1:0] cnt_inc;

  // A key that has not yet been counted either matches a stored key or
  // claims the first free cell it meets; free cells only ever follow used ones.
  assign match   = beat_i.valid && !beat_i.hit && valid_q && (key_q == beat_i.key);
  assign claim   = beat_i.valid && !beat_i.hit && !valid_q;
  assign cnt_inc = (cnt_q == smf_pkg::COUNT_MAX) ? cnt_q : cnt_q + smf_pkg::COUNT_ONE;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    cnt_d   = cnt_q;
    beat_d  = beat_i;
    if (match) begin
      cnt_d      = cnt_inc;
      beat_d.hit = 1'b1;
      beat_d.cnt = cnt_inc;
    end
    if (claim) begin
      valid_d    = 1'b1;
      key_d      = beat_i.key;
      cnt_d      = smf_pkg::COUNT_ONE;
      beat_d.hit = 1'b1;
      beat_d.cnt = smf_pkg::COUNT_ONE;
    end
    // The last key of a set frees the cell behind it as it passes.
    if (beat_i.valid && beat_i.last) begin
      valid_d = 1'b0;
    end
  end

  // Control state and the travelling beat are reset; the stored key and count are not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= '0;
    end else if (en_i) begin
      valid_q <= valid_d;
      beat_q  <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      key_q <= key_d;
      cnt_q <= cnt_d;
    end
  end

  assign beat_o = beat_q;

endmodule

// File: rtl/smf_tracker.sv
// Tail of the cell row: keeps the running best and the overflow flag.
module smf_tracker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  smf_pkg::smf_beat_t          beat_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [smf_pkg::KEY_W-1:0]   mode_value_o,
  output logic [smf_pkg::COUNT_W-1:0] mode_count_o,
  output logic                        table_overflow_o
);

  logic [smf_pkg::KEY_W-1:0]   best_key_q, best_key_d;
  logic [smf_pkg::COUNT_W-1:0] best_cnt_q, best_cnt_d;
  logic                        ovf_q, ovf_d;
  logic                        out_valid_q, out_valid_d;
  logic [smf_pkg::KEY_W-1:0]   mode_value_q;
  logic [smf_pkg::COUNT_W-1:0] mode_count_q;
  logic                        table_overflow_q;

  logic                        beat_take;
  logic                        better;
  logic [smf_pkg::KEY_W-1:0]   new_key;
  logic [smf_pkg::COUNT_W-1:0] new_cnt;
  logic                        new_ovf;

  // A key that no cell counted was dropped by a full row.
  assign beat_take = en_i && beat_i.valid;
  assign better    = beat_i.hit && (beat_i.cnt > best_cnt_q);
  assign new_key   = better ? beat_i.key : best_key_q;
  assign new_cnt   = better ? beat_i.cnt : best_cnt_q;
  assign new_ovf   = ovf_q || !beat_i.hit;

  always_comb begin
    best_key_d  = best_key_q;
    best_cnt_d  = best_cnt_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (beat_take) begin
      if (beat_i.last) begin
        best_key_d  = '0;
        best_cnt_d  = '0;
        ovf_d       = 1'b0;
        out_valid_d = 1'b1;
      end else begin
        best_key_d = new_key;
        best_cnt_d = new_cnt;
        ovf_d      = new_ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_key_q  <= '0;
      best_cnt_q  <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      best_key_q  <= best_key_d;
      best_cnt_q  <= best_cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register, loaded by the last key of a set.
  always_ff @(posedge clk_i) begin
    if (beat_take && beat_i.last) begin
      mode_value_q     <= new_key;
      mode_count_q     <= new_cnt;
      table_overflow_q <= new_ovf;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign mode_value_o     = mode_value_q;
  assign mode_count_o     = mode_count_q;
  assign table_overflow_o = table_overflow_q;

endmodule

// File: rtl/stream_mode_finder.sv
// Top level of the stream mode finder: a row of counting cells and a tracker.
// A key passes through each cell's beat register in turn, then the result register.
// Throughput: while not stalled, one key per cycle, each moving one cell per cycle.
// The whole row stalls while a finished result waits in the output register.
// Reset clears all cell valid bits, the running best and the overflow flag at once;
// after the last key of a set, each cell frees itself as that key passes.
module stream_mode_finder #(
  parameter int unsigned TABLE_ENTRIES = smf_pkg::TABLE_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] key_value
  input  logic        s_axis_tlast,   // last_item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] mode_value, [63:32] mode_count
  output logic [0:0]  m_axis_tuser    // [0] table_overflow
);

  smf_pkg::smf_beat_t          chain [TABLE_ENTRIES+1];
  logic                        en;
  logic [smf_pkg::KEY_W-1:0]   mode_value;
  logic [smf_pkg::COUNT_W-1:0] mode_count;
  logic                        table_overflow;

  // The row advances unless a result is held and not taken.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Beat entering the first cell.
  assign chain[0] = '{valid: s_axis_tvalid, key: s_axis_tdata, last: s_axis_tlast,
                      hit: 1'b0, cnt: '0};

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    smf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .beat_i (chain[i]),
      .beat_o (chain[i+1])
    );
  end

  smf_tracker u_tracker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .beat_i           (chain[TABLE_ENTRIES]),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .mode_value_o     (mode_value),
    .mode_count_o     (mode_count),
    .table_overflow_o (table_overflow)
  );

  assign m_axis_tdata = {mode_count, mode_value};
  assign m_axis_tuser = table_overflow;

endmodule
